[hdl/gbp_pkg.sv]
// Package for the Gaussian box projector: beat structs, store sizing and FSM codes.
// No dependencies; used by every file in hdl/.
package gbp_pkg;

    localparam int NUM_CAMERAS = 3;
    localparam int STORE_DEPTH = NUM_CAMERAS * 12;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CAM_W       = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int ACC_W       = 52;

    localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic [31:0]        var_x;
        logic [31:0]        var_y;
        logic [31:0]        var_z;
    } item_t;

    typedef struct packed {
        logic [1:0]         camera;
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic [31:0]        box_width;
        logic [31:0]        box_height;
        logic               bad_divisor;
        logic               last;
    } result_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic        sat;
    } div_res_t;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_RD    = 14'b00000000000010,
        ST_MUL   = 14'b00000000000100,
        ST_ACC   = 14'b00000000001000,
        ST_DIV   = 14'b00000000010000,
        ST_BRD   = 14'b00000000100000,
        ST_BSQ   = 14'b00000001000000,
        ST_BLO   = 14'b00000010000000,
        ST_BHI   = 14'b00000100000000,
        ST_BACC  = 14'b00001000000000,
        ST_SQRT  = 14'b00010000000000,
        ST_SCALE = 14'b00100000000000,
        ST_SAT   = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

endpackage

[hdl/gbp_div.sv]
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
// Depends on gbp_pkg.
module gbp_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [gbp_pkg::ACC_W-1:0] num,
    input  logic signed [gbp_pkg::ACC_W-1:0] den,
    output gbp_pkg::div_res_t                res
);

    localparam int W = gbp_pkg::ACC_W;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dmag_reg, dmag_next;
    logic [32:0]  sh_reg, sh_next;
    logic [32:0]  quo_reg, quo_next;
    logic         neg_reg, neg_next;

    logic [W-1:0] nmag, dmag_in;
    logic [W:0]   rem2;
    logic         ge;

    always_comb
    begin
        nmag    = num[W-1] ? W'(-num) : W'(num);
        dmag_in = den[W-1] ? W'(-den) : W'(den);
        rem2    = {rem_reg, sh_reg[32]};
        ge      = rem2 >= {1'b0, dmag_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            neg_next  = num[W-1] ^ den[W-1];
            dmag_next = dmag_in;
            // quotient of 2^33 or more: saturates regardless of low bits
            if ({17'b0, nmag} >= {dmag_in, 17'b0})
            begin
                quo_next  = 33'h1_FFFF_FFFF;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = W'(nmag >> 17);
                sh_next   = {nmag[16:0], 16'b0};
                quo_next  = '0;
                cnt_next  = 6'd33;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? W'(rem2 - {1'b0, dmag_reg}) : W'(rem2);
            quo_next = {quo_reg[31:0], ge};
            sh_next  = {sh_reg[31:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        sh_reg   <= sh_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        res.done = done_reg;
        if (neg_reg)
        begin
            res.sat = quo_reg > 33'h0_8000_0000;
            res.quo = res.sat ? 32'h8000_0000 : 32'(-quo_reg[31:0]);
        end
        else
        begin
            res.sat = quo_reg > 33'h0_7FFF_FFFF;
            res.quo = res.sat ? 32'h7FFF_FFFF : quo_reg[31:0];
        end
    end

endmodule

[hdl/gaussian_box_projector_core.sv]
// Gaussian box projector top level: coefficient store, shared multiplier, square root
// and sequencer. Depends on gbp_pkg and gbp_div.
//
// Usage:
//   item/item_valid/item_stall: one beat per command. A load beat (cmd 0) writes one
//   coefficient of the 3x4 camera matrices; an index beyond the store is dropped. A
//   project beat (cmd 1) produces one result beat per camera, in camera order, with
//   last set on the final one.
//   cfg_valid/cfg_ready/cfg_data: writes scale_factor; always ready.
//   Sequencing: item_stall is high from a project beat until its last result is
//   taken, so a new item is not taken while one is in progress. Each camera runs
//   three 4-term dot products on the shared 33x33 multiplier, two divides (cut
//   short when the quotient saturates at once, none when w is zero), two box sizes
//   (squares and variance products on the multiplier, a square root, scale and
//   saturate) and the result beat; result stalls hold the sequencer.
//   Reset clears the sequencer and sets scale_factor to 1.0; coefficients must be
//   loaded before projecting. A stalled result holds steady and the sequencer waits.
module gaussian_box_projector_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  gbp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output gbp_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    localparam int AW = gbp_pkg::ADDR_W;
    localparam int CW = gbp_pkg::CAM_W;
    localparam int W  = gbp_pkg::ACC_W;

    gbp_pkg::state_t state_reg, state_next;

    logic [31:0]          scale_reg;
    logic [CW-1:0]        cam_reg, cam_next;
    logic [1:0]           row_reg, row_next;
    logic [1:0]           col_reg, col_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 bad_reg, bad_next;

    gbp_pkg::item_t       it_reg;
    logic signed [31:0]   coef_reg;
    logic signed [W-1:0]  acc_reg, acc_next;
    logic signed [W-1:0]  w_reg, w_next;
    logic signed [65:0]   prod_reg, prod_next;
    logic [14:0]          sqhi_reg, sqhi_next;
    logic [63:0]          lo_reg, lo_next;
    logic [47:0]          sum_reg, sum_next;
    logic [63:0]          sv_reg, sv_next;
    logic [63:0]          res_reg, res_next;
    logic [63:0]          bit_reg, bit_next;
    logic [31:0]          bx_reg, bx_next, by_reg, by_next;
    logic [31:0]          bw_reg, bw_next, bh_reg, bh_next;

    logic [31:0]          mem [gbp_pkg::STORE_DEPTH];
    logic [AW-1:0]        rd_addr;
    logic                 accept, wr_en;

    logic signed [32:0]   mul_a, mul_b;
    logic [31:0]          coef_mag;
    logic signed [31:0]   mean_sel;
    logic [31:0]          var_sel;
    logic signed [W-1:0]  dot_term;
    logic [77:0]          full_prod;
    logic [47:0]          term;
    logic [48:0]          sum_wide;
    logic [63:0]          trial;

    logic                 div_start;
    gbp_pkg::div_res_t    div_res;

    gbp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_next),
        .den   (w_reg),
        .res   (div_res)
    );

    assign item_stall   = (state_reg != gbp_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign wr_en        = accept && (item.cmd == gbp_pkg::CMD_LOAD)
                          && (int'(item.coef_index) < gbp_pkg::STORE_DEPTH);
    assign cfg_ready    = 1'b1;
    assign result_valid = (state_reg == gbp_pkg::ST_OUT);

    always_comb
    begin
        result.camera      = 2'(cam_reg);
        result.box_x       = bx_reg;
        result.box_y       = by_reg;
        result.box_width   = bw_reg;
        result.box_height  = bh_reg;
        result.bad_divisor = bad_reg;
        result.last        = (int'(cam_reg) == gbp_pkg::NUM_CAMERAS - 1);
    end

    // store: rows 0..2 of camera cam at cam*12 + row*4 + col
    assign rd_addr = AW'(int'(cam_reg) * 12 + int'(row_reg) * 4 + int'(col_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(item.coef_index)] <= item.coef_value;
        end
        coef_reg <= mem[rd_addr];
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        coef_mag = coef_reg[31] ? 32'(-coef_reg) : 32'(coef_reg);
        case (col_reg)
            2'd0:    begin mean_sel = it_reg.mean_x; var_sel = it_reg.var_x; end
            2'd1:    begin mean_sel = it_reg.mean_y; var_sel = it_reg.var_y; end
            default: begin mean_sel = it_reg.mean_z; var_sel = it_reg.var_z; end
        endcase
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gbp_pkg::ST_MUL:
            begin
                mul_a = 33'(coef_reg);
                mul_b = 33'(mean_sel);
            end
            gbp_pkg::ST_BSQ:
            begin
                mul_a = {1'b0, coef_mag};
                mul_b = {1'b0, coef_mag};
            end
            gbp_pkg::ST_BLO:
            begin
                mul_a = {1'b0, prod_reg[47:16]};
                mul_b = {1'b0, var_sel};
            end
            gbp_pkg::ST_BHI:
            begin
                mul_a = {18'b0, sqhi_reg};
                mul_b = {1'b0, var_sel};
            end
            gbp_pkg::ST_SCALE:
            begin
                mul_a = {1'b0, res_reg[31:0]};
                mul_b = {1'b0, scale_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        dot_term  = (col_reg == 2'd3) ? W'(coef_reg) : W'(prod_reg >>> 16);
        full_prod = 78'(lo_reg) + {prod_reg[45:0], 32'b0};
        term      = (|full_prod[77:64]) ? gbp_pkg::VAR_MAX : full_prod[63:16];
        sum_wide  = {1'b0, sum_reg} + {1'b0, term};
        trial     = res_reg + bit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cam_next   = cam_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        acc_next   = acc_reg;
        w_next     = w_reg;
        sqhi_next  = sqhi_reg;
        lo_next    = lo_reg;
        sum_next   = sum_reg;
        sv_next    = sv_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        bw_next    = bw_reg;
        bh_next    = bh_reg;
        div_start  = 1'b0;

        case (state_reg)
            gbp_pkg::ST_IDLE:
            begin
                if (accept && item.cmd == gbp_pkg::CMD_PROJECT)
                begin
                    cam_next   = '0;
                    row_next   = 2'd2;
                    col_next   = 2'd0;
                    acc_next   = '0;
                    bad_next   = 1'b0;
                    state_next = gbp_pkg::ST_RD;
                end
            end
            gbp_pkg::ST_RD:  state_next = gbp_pkg::ST_MUL;
            gbp_pkg::ST_MUL: state_next = gbp_pkg::ST_ACC;
            gbp_pkg::ST_ACC:
            begin
                acc_next = acc_reg + dot_term;
                if (col_reg != 2'd3)
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = gbp_pkg::ST_RD;
                end
                else if (row_reg == 2'd2)
                begin
                    w_next     = acc_next;
                    acc_next   = '0;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    state_next = gbp_pkg::ST_RD;
                end
                else if (w_reg == '0)
                begin
                    bad_next   = 1'b1;
                    if (row_reg == 2'd0)
                        bx_next = '0;
                    else
                        by_next = '0;
                    col_next   = 2'd0;
                    sum_next   = '0;
                    state_next = gbp_pkg::ST_BRD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = gbp_pkg::ST_DIV;
                end
            end
            gbp_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (row_reg == 2'd0)
                        bx_next = div_res.quo;
                    else
                        by_next = div_res.quo;
                    bad_next   = bad_reg | div_res.sat;
                    col_next   = 2'd0;
                    sum_next   = '0;
                    state_next = gbp_pkg::ST_BRD;
                end
            end
            gbp_pkg::ST_BRD: state_next = gbp_pkg::ST_BSQ;
            gbp_pkg::ST_BSQ: state_next = gbp_pkg::ST_BLO;
            gbp_pkg::ST_BLO:
            begin
                sqhi_next  = prod_reg[62:48];
                state_next = gbp_pkg::ST_BHI;
            end
            gbp_pkg::ST_BHI:
            begin
                lo_next    = prod_reg[63:0];
                state_next = gbp_pkg::ST_BACC;
            end
            gbp_pkg::ST_BACC:
            begin
                sum_next = sum_wide[48] ? gbp_pkg::VAR_MAX : sum_wide[47:0];
                if (col_reg != 2'd2)
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = gbp_pkg::ST_BRD;
                end
                else
                begin
                    sv_next    = {sum_next, 16'b0};
                    res_next   = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    cnt_next   = 6'd32;
                    state_next = gbp_pkg::ST_SQRT;
                end
            end
            gbp_pkg::ST_SQRT:
            begin
                if (sv_reg >= trial)
                begin
                    sv_next  = sv_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = gbp_pkg::ST_SCALE;
            end
            gbp_pkg::ST_SCALE: state_next = gbp_pkg::ST_SAT;
            gbp_pkg::ST_SAT:
            begin
                if (row_reg == 2'd0)
                begin
                    bw_next    = (|prod_reg[63:48]) ? 32'hFFFF_FFFF : prod_reg[47:16];
                    row_next   = 2'd1;
                    col_next   = 2'd0;
                    acc_next   = '0;
                    state_next = gbp_pkg::ST_RD;
                end
                else
                begin
                    bh_next    = (|prod_reg[63:48]) ? 32'hFFFF_FFFF : prod_reg[47:16];
                    state_next = gbp_pkg::ST_OUT;
                end
            end
            gbp_pkg::ST_OUT:
            begin
                if (!result_stall)
                begin
                    if (int'(cam_reg) == gbp_pkg::NUM_CAMERAS - 1)
                    begin
                        state_next = gbp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cam_next   = cam_reg + CW'(1);
                        row_next   = 2'd2;
                        col_next   = 2'd0;
                        acc_next   = '0;
                        bad_next   = 1'b0;
                        state_next = gbp_pkg::ST_RD;
                    end
                end
            end
            default: state_next = gbp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbp_pkg::ST_IDLE;
            scale_reg <= 32'h0001_0000;
            cam_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                scale_reg <= cfg_data;
            cam_reg   <= cam_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            it_reg <= item;
        acc_reg  <= acc_next;
        w_reg    <= w_next;
        prod_reg <= prod_next;
        sqhi_reg <= sqhi_next;
        lo_reg   <= lo_next;
        sum_reg  <= sum_next;
        sv_reg   <= sv_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        bw_reg   <= bw_next;
        bh_reg   <= bh_next;
    end

endmodule

[hdl/gbp_checker.sv]
// Port-level checks for the Gaussian box projector, bound to the top level.
// Depends on gbp_pkg and gaussian_box_projector_core.
module gbp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input gbp_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input gbp_pkg::result_t result
);

    // a stalled item beat stays offered and unchanged
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("item beat changed while stalled");

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result beat changed while stalled");

    // no new item while results are pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item taken while results pending");

    // result_valid drops after each taken beat: no back-to-back result beats
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall |=> !result_valid)
        else $error("result beats back to back");

endmodule

bind gaussian_box_projector_core gbp_checker u_gbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[tb/sv/tb_gaussian_box_projector_core.sv]
// Testbench for gaussian_box_projector_core: loads camera matrices, projects Gaussians
// and checks every result beat against an in-bench fixed-point predictor. Needs gbp_pkg.
module tb_gaussian_box_projector_core;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    gbp_pkg::item_t   item;
    logic    result_valid;
    logic    result_stall;
    gbp_pkg::result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [31:0] cfg_data;

    gaussian_box_projector_core uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    // predictor state
    logic signed [63:0] coef_mirror [gbp_pkg::STORE_DEPTH];
    logic [31:0]        scale_mirror;
    gbp_pkg::result_t   pending_boxes [$];

    int  errors;
    int  idle_pct;
    int  quiet_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic signed [63:0] floor_q16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] row_dot(input int base,
        input logic signed [63:0] mx, my, mz);
        return floor_q16(coef_mirror[base] * mx) + floor_q16(coef_mirror[base+1] * my)
             + floor_q16(coef_mirror[base+2] * mz) + coef_mirror[base+3];
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [31:0] q16_quotient(input logic signed [63:0] num,
        input logic signed [63:0] w, inout bit sat);
        logic [63:0] q;
        bit neg;
        q = (abs64(num) << 16) / abs64(w);
        neg = (num < 0) != (w < 0);
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1;
                q = 64'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1;
            q = 64'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] box_extent(input int base, input logic [63:0] vx,
        input logic [63:0] vy, input logic [63:0] vz);
        logic [63:0] vars [3];
        logic [63:0] sum, m, sq, term, root, box;
        logic [127:0] wide;
        vars[0] = vx; vars[1] = vy; vars[2] = vz;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            m = abs64(coef_mirror[base+k]);
            sq = (m * m) >> 16;
            wide = 128'(sq) * 128'(vars[k]);
            term = (wide[127:64] != 0) ? 64'(gbp_pkg::VAR_MAX) : wide[63:0] >> 16;
            if (term > 64'(gbp_pkg::VAR_MAX)) term = 64'(gbp_pkg::VAR_MAX);
            sum += term;
            if (sum > 64'(gbp_pkg::VAR_MAX)) sum = 64'(gbp_pkg::VAR_MAX);
        end
        root = int_sqrt(sum << 16);
        box = (root * 64'(scale_mirror)) >> 16;
        return box > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : box[31:0];
    endfunction

    // mirrors one accepted item into the store or the expected-box queue
    function automatic void predict_item(input gbp_pkg::item_t it);
        logic signed [63:0] mx, my, mz, w;
        gbp_pkg::result_t r;
        bit sat;
        if (it.cmd == gbp_pkg::CMD_LOAD)
        begin
            if (it.coef_index < gbp_pkg::STORE_DEPTH)
                coef_mirror[it.coef_index] = it.coef_value;
            return;
        end
        mx = it.mean_x; my = it.mean_y; mz = it.mean_z;
        for (int c = 0; c < gbp_pkg::NUM_CAMERAS; c++)
        begin
            sat = 0;
            w = row_dot(c*12 + 8, mx, my, mz);
            r.camera = 2'(c);
            r.box_x = 0;
            r.box_y = 0;
            if (w == 0)
                sat = 1;
            else
            begin
                r.box_x = q16_quotient(row_dot(c*12, mx, my, mz), w, sat);
                r.box_y = q16_quotient(row_dot(c*12 + 4, mx, my, mz), w, sat);
            end
            r.box_width = box_extent(c*12, it.var_x, it.var_y, it.var_z);
            r.box_height = box_extent(c*12 + 4, it.var_x, it.var_y, it.var_z);
            r.bad_divisor = sat;
            r.last = (c == gbp_pkg::NUM_CAMERAS - 1);
            pending_boxes.push_back(r);
        end
    endfunction

    // valid stays up after the beat; the next beat, an idle cycle or a drain drops it
    task automatic send_item(input gbp_pkg::item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_scale(input logic [31:0] v);
        wait_drained();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        scale_mirror = v;
    endtask

    function automatic gbp_pkg::item_t load_beat(input int idx, input logic [31:0] v);
        gbp_pkg::item_t it;
        it = '0;
        it.cmd = gbp_pkg::CMD_LOAD;
        it.coef_index = 6'(idx);
        it.coef_value = v;
        it.mean_x = $urandom;
        it.var_z = $urandom;
        return it;
    endfunction

    function automatic gbp_pkg::item_t project_beat(input logic [31:0] mx, my, mz,
        vx, vy, vz);
        gbp_pkg::item_t it;
        it.cmd = gbp_pkg::CMD_PROJECT;
        it.coef_index = 6'($urandom);
        it.coef_value = $urandom;
        it.mean_x = mx; it.mean_y = my; it.mean_z = mz;
        it.var_x = vx; it.var_y = vy; it.var_z = vz;
        return it;
    endfunction

    // a modest random coefficient, mostly in a camera-like range
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(65536*8)) - 65536*4);
            default: return 32'($signed($urandom_range(65536*1000)) - 65536*500);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(65536*20)) - 65536*10);
            2: return $urandom_range(65536*4);
            default: return 32'h8000_0000 | 32'($urandom_range(1));
        endcase
    endfunction

    task automatic load_all(input bit randomize);
        for (int i = 0; i < gbp_pkg::STORE_DEPTH; i++)
            send_item(load_beat(i, randomize ? rand_coef() : 32'(i) << 16));
    endtask

    task automatic test_directed();
        // ramp coefficients, zero w on camera 1 row 2, later a huge one on camera 2
        load_all(0);
        for (int i = 8; i < 12; i++)
            send_item(load_beat(12 + i, 32'h0));
        send_item(load_beat(63, 32'hFFFF_FFFF));
        send_item(load_beat(gbp_pkg::STORE_DEPTH, 32'h1234_5678));
        send_item(project_beat(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                               32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_item(project_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(project_beat(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_item(load_beat(32, 32'h7FFF_FFFF));
        send_item(load_beat(0, 32'h8000_0000));
        send_item(load_beat(35, 32'h0000_0001));
        send_item(project_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h0, 32'hFFFF_FFFF, 32'h1));
        send_item(project_beat(32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000,
                               32'h1234_5678, 32'h0, 32'h8765_4321));
    endtask

    task automatic test_scale_extremes();
        write_scale(32'h0);
        send_item(project_beat(32'h0001_0000, 32'h1, 32'h2, 32'h0010_0000, 32'h5, 32'h7));
        write_scale(32'hFFFF_FFFF);
        send_item(project_beat(32'h0003_0000, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h5, 32'h7));
        write_scale(32'h0002_8000);
    endtask

    task automatic test_random(input int count);
        int n;
        n = 0;
        load_all(1);
        while (n < count)
        begin
            if (n == count / 2)
            begin
                wait_drained();  // hold off until the block has emptied
                write_scale($urandom);
            end
            if (n > count / 4 && n < count / 2)
                idle_pct = 0;
            else
                idle_pct = 30;
            if ($urandom_range(99) < 35)
                send_item(load_beat($urandom_range(63), rand_coef()));
            else
                send_item(project_beat(rand_word(), rand_word(), rand_word(),
                                       rand_word(), rand_word(), rand_word()));
            n++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        gbp_pkg::result_t exp_box;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_boxes.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, result);
                errors++;
            end
            else
            begin
                exp_box = pending_boxes.pop_front();
                if (result.camera !== exp_box.camera)
                    $display("%0t: camera exp %0d got %0d", $time, exp_box.camera,
                             result.camera);
                if (result.box_x !== exp_box.box_x)
                    $display("%0t: box_x exp %h got %h", $time, exp_box.box_x, result.box_x);
                if (result.box_y !== exp_box.box_y)
                    $display("%0t: box_y exp %h got %h", $time, exp_box.box_y, result.box_y);
                if (result.box_width !== exp_box.box_width)
                    $display("%0t: box_width exp %h got %h", $time, exp_box.box_width,
                             result.box_width);
                if (result.box_height !== exp_box.box_height)
                    $display("%0t: box_height exp %h got %h", $time, exp_box.box_height,
                             result.box_height);
                if (result.bad_divisor !== exp_box.bad_divisor)
                    $display("%0t: bad_divisor exp %b got %b", $time, exp_box.bad_divisor,
                             result.bad_divisor);
                if (result.last !== exp_box.last)
                    $display("%0t: last exp %b got %b", $time, exp_box.last, result.last);
                if (result !== exp_box)
                    errors++;
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (idle_pct == 0)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 30);
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("gaussian_box_projector_core verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_pct = 30;
        quiet_cycles = 0;
        scale_mirror = 32'h0001_0000;
        for (int i = 0; i < gbp_pkg::STORE_DEPTH; i++)
            coef_mirror[i] = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_scale_extremes();
        test_random(110);
        wait_drained();
        if (errors == 0)
            $display("gaussian_box_projector_core verification clean");
        else
            $display("gaussian_box_projector_core verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/gbp_pkg.sv
hdl/gbp_div.sv
hdl/gaussian_box_projector_core.sv
hdl/gbp_checker.sv
tb/sv/tb_gaussian_box_projector_core.sv
